>>> rtl/twm_pkg.sv
`timescale 1ns / 1ps

package twm_pkg;

    localparam int PhaseW = 3;
    localparam int ByteBits = 8;
    localparam int BitIdxW = 4;

    // Sequencer phase codes
    localparam logic [PhaseW-1:0] PH_IDLE       = 3'd0;
    localparam logic [PhaseW-1:0] PH_SETUP_LOW  = 3'd1;
    localparam logic [PhaseW-1:0] PH_SETUP_HIGH = 3'd2;
    localparam logic [PhaseW-1:0] PH_SEND_LOW   = 3'd3;
    localparam logic [PhaseW-1:0] PH_SEND_HIGH  = 3'd4;
    localparam logic [PhaseW-1:0] PH_RECV_LOW   = 3'd5;
    localparam logic [PhaseW-1:0] PH_RECV_HIGH  = 3'd6;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CMD_READ_BIT = 8'h01;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       data_in;
    } twm_in_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       rejected;
    } twm_out_t;

    typedef struct packed {
        logic [PhaseW-1:0]  phase;
        logic [BitIdxW-1:0] bit_index;
        logic [7:0]         tick_count;
        logic [15:0]        send_shift;
        logic [7:0]         receive_shift;
        logic               is_read;
        logic               ce;
        logic               clk;
        logic               dout;
        logic               drive;
    } twm_state_t;

    // Idle, pins low, data line driven
    localparam twm_state_t STATE_RESET = '{
        phase:         PH_IDLE,
        bit_index:     4'd0,
        tick_count:    8'h00,
        send_shift:    16'h0000,
        receive_shift: 8'h00,
        is_read:       1'b0,
        ce:            1'b0,
        clk:           1'b0,
        dout:          1'b0,
        drive:         1'b1
    };

endpackage

>>> rtl/twm_step.sv
`timescale 1ns / 1ps

module twm_step (
    input  twm_pkg::twm_state_t cur,
    input  twm_pkg::twm_in_t    word,
    input  logic [7:0]          half_period_ticks,
    output twm_pkg::twm_state_t nxt,
    output twm_pkg::twm_out_t   res
);
    import twm_pkg::*;

    logic [7:0]         period;
    logic               start;
    logic [7:0]         tick;
    logic [BitIdxW:0]   bit_inc;
    logic [BitIdxW:0]   total;
    logic               done;

    always_comb begin
        period  = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
        start   = word.op inside {OP_WRITE, OP_READ};
        tick    = cur.tick_count + 8'd1;
        bit_inc = {1'b0, cur.bit_index} + 5'd1;
        total   = cur.is_read ? 5'(ByteBits) : 5'(2 * ByteBits);
        done    = 1'b0;
        nxt     = cur;
        res     = '0;

        if (cur.phase > PH_RECV_HIGH) begin
            nxt.phase = PH_IDLE;
        end

        if (nxt.phase == PH_IDLE) begin
            if (start) begin
                nxt.is_read       = (word.op == OP_READ);
                nxt.send_shift    = (word.op == OP_READ) ?
                                    {8'h00, word.address | CMD_READ_BIT} :
                                    {word.write_data, word.address & ~CMD_READ_BIT};
                nxt.receive_shift = '0;
                nxt.bit_index     = '0;
                nxt.tick_count    = '0;
                nxt.phase         = PH_SETUP_LOW;
                nxt.ce            = 1'b0;
                nxt.clk           = 1'b0;
                nxt.drive         = 1'b1;
            end
        end else begin
            res.rejected   = start;
            nxt.tick_count = tick;
            if (tick >= period) begin
                nxt.tick_count = '0;
                case (cur.phase)
                    PH_SETUP_LOW: begin
                        nxt.phase = PH_SETUP_HIGH;
                        nxt.ce    = 1'b1;
                    end
                    PH_SETUP_HIGH: begin
                        nxt.bit_index = '0;
                        nxt.phase     = PH_SEND_LOW;
                        nxt.clk       = 1'b0;
                        nxt.drive     = 1'b1;
                        nxt.dout      = cur.send_shift[0];
                    end
                    PH_SEND_LOW: begin
                        nxt.phase = PH_SEND_HIGH;
                        nxt.clk   = 1'b1;
                    end
                    PH_SEND_HIGH: begin
                        if (bit_inc < total) begin
                            nxt.bit_index = bit_inc[BitIdxW-1:0];
                            nxt.phase     = PH_SEND_LOW;
                            nxt.clk       = 1'b0;
                            nxt.drive     = 1'b1;
                            nxt.dout      = cur.send_shift[bit_inc[BitIdxW-1:0]];
                        end else if (cur.is_read) begin
                            nxt.bit_index = '0;
                            nxt.phase     = PH_RECV_LOW;
                            nxt.clk       = 1'b0;
                            nxt.drive     = 1'b0;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_RECV_LOW: begin
                        nxt.phase = PH_RECV_HIGH;
                        nxt.clk   = 1'b1;
                    end
                    PH_RECV_HIGH: begin
                        nxt.receive_shift[cur.bit_index[2:0]] =
                            cur.receive_shift[cur.bit_index[2:0]] | word.data_in;
                        if (cur.bit_index < BitIdxW'(ByteBits - 1)) begin
                            nxt.bit_index = bit_inc[BitIdxW-1:0];
                            nxt.phase     = PH_RECV_LOW;
                            nxt.clk       = 1'b0;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        nxt.phase = PH_IDLE;
                    end
                endcase
                if (done) begin
                    nxt.ce    = 1'b0;
                    nxt.clk   = 1'b0;
                    nxt.phase = PH_IDLE;
                end
            end
        end

        res.chip_enable  = nxt.ce;
        res.serial_clock = nxt.clk;
        res.data_out     = nxt.dout;
        res.data_drive   = nxt.drive;
        res.busy_res     = (nxt.phase != PH_IDLE);
        res.done_res     = done;
        res.read_data    = (done && cur.is_read) ? nxt.receive_shift : 8'h00;
    end

endmodule

>>> rtl/three_wire_register_master_core.sv
`timescale 1ns / 1ps

// Three-wire register bus master: sequences chip enable, serial clock and a
// bidirectional data line to write or read one register per transaction.
//
// Input channel (s_valid/s_ready/s_data): each word is one time tick or a
// start command (write or read). Every word yields exactly one result word on
// the output channel (m_valid/m_ready/m_data) carrying the pin levels after
// that tick, busy, a one-word done pulse, read data and a reject flag.
//
// Each word passes through two registers: the input register, then the
// sequencer step into the result register. The core takes one word per
// cycle while the receiver does not stall; the sequencer step between the
// two registers is combinational.
//
// Reset (aresetn low, synchronous): sequencer idle, pins low with data driven,
// half_period_ticks back to 1, both registers empty.
//
// When the receiver stalls, the result register holds its word, the input
// register fills, and s_ready drops until m_ready returns. No word is lost.
// Write half_period_ticks through cfg_wr_en/cfg_wr_data only while no word is
// in flight; a new period takes effect at once, even mid-transaction.
module three_wire_register_master_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  twm_pkg::twm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output twm_pkg::twm_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);
    import twm_pkg::*;

    logic       in_valid_reg;
    twm_in_t    in_data_reg;
    logic       out_valid_reg;
    twm_out_t   out_data_reg;
    twm_state_t state_reg;
    twm_state_t state_next;
    twm_out_t   res_next;
    logic [7:0] hpt_reg;
    logic       step;

    // Step the sequencer when a word is held and the result slot frees up.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    twm_step u_step (
        .cur               (state_reg),
        .word              (in_data_reg),
        .half_period_ticks (hpt_reg),
        .nxt               (state_next),
        .res               (res_next)
    );

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hpt_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            hpt_reg <= cfg_wr_data;
        end
    end

    // Input register: load on accept, drop once stepped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Sequencer state advances once per stepped word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    // Result register: hold while stalled, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= res_next;
        end
    end

    // Done always leaves the sequencer idle with CE and clock low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.done_res |->
            !out_data_reg.busy_res && !out_data_reg.chip_enable
            && !out_data_reg.serial_clock)
        else $error("done with bus still active");

    // A reject can only come from a word stepped while a transaction ran.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_next.rejected |-> state_reg.phase != PH_IDLE)
        else $error("reject while idle");

    // Result word matches the sequencer state it left behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_data_reg.busy_res == (state_reg.phase != PH_IDLE))
        else $error("busy out of step with sequencer");

    // After reset the sequencer is idle and drives the data line.
    assert property (@(posedge aclk)
        !aresetn |=> state_reg.phase == PH_IDLE && state_reg.drive)
        else $error("bad state after reset");

    // A stalled result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !step)
        else $error("stepped into a stalled result");

endmodule
